[sv/point_grid_height_binning_defines.svh]
// assertion macros used by the point grid height binning datapath
`ifndef POINT_GRID_HEIGHT_BINNING_DEFINES_SVH
`define POINT_GRID_HEIGHT_BINNING_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication check
`define PGH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// next-cycle implication check
`define PGH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`else

`define PGH_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PGH_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[sv/pgh_pkg.sv]
// shared widths, codes and controller/datapath interface types
package pgh_pkg;

  // field widths
  localparam int COORD_W    = 24;
  localparam int SIZE_W     = 16;
  localparam int GRID_W     = 7;
  localparam int GRID_MAX   = (1 << GRID_W) - 1;
  localparam int IDX_W      = 2 * GRID_W;
  localparam int CNT_W      = 16;
  localparam int SUM_W      = 40;
  localparam int OUT_RC_W   = 6;

  // stream payload layout
  localparam int IN_TDATA_W    = 3 * COORD_W;
  localparam int OUT_FIELDS_W  = 2 * OUT_RC_W + CNT_W + COORD_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // shared divider
  localparam int DIV_W      = SUM_W;
  localparam int ITER_W     = 6;
  localparam logic [ITER_W-1:0] PT_ITERS   = ITER_W'(COORD_W);
  localparam logic [ITER_W-1:0] IDX_ITERS  = ITER_W'(IDX_W);
  localparam logic [ITER_W-1:0] MEAN_ITERS = ITER_W'(SUM_W);

  // input command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CELL_SZ_X = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_CELL_SZ_Y = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_GRID_COLS = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_GRID_ROWS = 3'd5;

  // configuration reset values
  localparam logic [SIZE_W-1:0] CELL_SZ_RST   = SIZE_W'(100);
  localparam logic [GRID_W-1:0] GRID_DIM_RST  = GRID_W'(64);

  // divider operand select
  typedef enum logic [1:0] {
    DIV_X,
    DIV_Y,
    DIV_IDX,
    DIV_MEAN
  } div_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     load_item;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_x;
    logic     cap_y;
    logic     cap_idx;
    logic     cap_mean;
    logic     wrap_idx;
    logic     adv_idx;
    logic     mem_rd;
    logic     mem_upd;
    logic     mem_clr;
    logic     clr_step;
    logic     out_load;
  } pgh_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic clr_last;
    logic pt_reject;
    logic cell_ok;
    logic cell_empty;
    logic out_free;
  } pgh_sts_t;

endpackage

[sv/pgh_div.sv]
// shared restoring divider, one quotient bit per cycle
module pgh_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pgh_pkg::DIV_W-1:0]   dividend,
  input  logic [pgh_pkg::SIZE_W-1:0]  divisor,
  input  logic [pgh_pkg::ITER_W-1:0]  iters,
  output logic                        busy,
  output logic                        done,
  output logic [pgh_pkg::DIV_W-1:0]   quotient,
  output logic [pgh_pkg::SIZE_W-1:0]  remainder
);
  import pgh_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [ITER_W-1:0]   left_r;
  logic [DIV_W-1:0]    q_r;
  logic [SIZE_W-1:0]   rem_r;
  logic [SIZE_W-1:0]   dvs_r;
  logic [SIZE_W:0]     shifted;
  logic [SIZE_W:0]     diff;
  logic                fits;

  // trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem_r, q_r[DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = ~diff[SIZE_W];

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      left_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        left_r <= iters;
      end else if (busy_r) begin
        left_r <= left_r - ITER_W'(1);
        if (left_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DIV_W-2:0], fits};
      rem_r <= fits ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

[sv/pgh_dpath.sv]
// datapath: configuration, item registers, cell memory, divider and result register
`include "point_grid_height_binning_defines.svh"

module pgh_dpath #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [pgh_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pgh_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pgh_pkg::COORD_W-1:0]       cfg_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pgh_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast,
  input  pgh_pkg::pgh_cmd_t                 cmd,
  output pgh_pkg::pgh_sts_t                 sts
);
  import pgh_pkg::*;

  localparam int CELLS   = MAX_ROWS * MAX_COLS;
  localparam int AW      = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_CAP = (MAX_COLS < GRID_MAX) ? MAX_COLS : GRID_MAX;
  localparam int ROW_CAP = (MAX_ROWS < GRID_MAX) ? MAX_ROWS : GRID_MAX;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
  } cell_t;

  // configuration registers
  logic signed [COORD_W-1:0] origin_x_r;
  logic signed [COORD_W-1:0] origin_y_r;
  logic [SIZE_W-1:0]         cell_sz_x_r;
  logic [SIZE_W-1:0]         cell_sz_y_r;
  logic [GRID_W-1:0]         grid_cols_r;
  logic [GRID_W-1:0]         grid_rows_r;

  // item and working registers
  logic signed [COORD_W:0]   dx_r;
  logic signed [COORD_W:0]   dy_r;
  logic signed [COORD_W-1:0] pt_z_r;
  logic [CW-1:0]             col_r;
  logic [RW-1:0]             row_r;
  logic                      col_ok_r;
  logic                      row_ok_r;
  logic [IDX_W-1:0]          ridx_r;
  logic                      last_r;
  logic signed [COORD_W-1:0] mean_r;
  logic [AW-1:0]             clr_addr_r;

  // memory and read register
  cell_t                     mem [CELLS];
  cell_t                     rdata_r;

  // result register
  logic                      out_tvalid_r;
  logic [OUT_RC_W-1:0]       out_row_r;
  logic [OUT_RC_W-1:0]       out_col_r;
  logic [CNT_W-1:0]          out_cnt_r;
  logic signed [COORD_W-1:0] out_mean_r;
  logic                      out_surf_r;
  logic                      out_last_r;

  // combinational
  logic [GRID_W-1:0]         eff_cols;
  logic [GRID_W-1:0]         eff_rows;
  logic [IDX_W-1:0]          total;
  logic [IDX_W-1:0]          ridx_eff;
  logic [AW-1:0]             cell_addr;
  logic [AW-1:0]             mem_addr;
  logic                      mem_we;
  cell_t                     mem_wdata;
  cell_t                     upd_cell;
  logic                      sat;
  logic [SUM_W-1:0]          sum_mag;
  logic [COORD_W-1:0]        quot_lo;
  logic [DIV_W-1:0]          div_dividend;
  logic [SIZE_W-1:0]         div_divisor;
  logic [ITER_W-1:0]         div_iters;
  logic                      div_busy;
  logic                      div_done;
  logic [DIV_W-1:0]          div_q;
  logic [SIZE_W-1:0]         div_rem;
  logic [15:0]               row_ext;
  logic [15:0]               col_ext;
  logic signed [COORD_W-1:0] in_x;
  logic signed [COORD_W-1:0] in_y;

  assign in_x = in_tdata[COORD_W-1:0];
  assign in_y = in_tdata[2*COORD_W-1:COORD_W];

  // grid size in use: zero acts as one, clamp at the array size
  always_comb begin
    if (grid_cols_r == '0) begin
      eff_cols = GRID_W'(1);
    end else if (grid_cols_r > GRID_W'(COL_CAP)) begin
      eff_cols = GRID_W'(COL_CAP);
    end else begin
      eff_cols = grid_cols_r;
    end
    if (grid_rows_r == '0) begin
      eff_rows = GRID_W'(1);
    end else if (grid_rows_r > GRID_W'(ROW_CAP)) begin
      eff_rows = GRID_W'(ROW_CAP);
    end else begin
      eff_rows = grid_rows_r;
    end
  end

  // raster position, restarting when it lies beyond the grid
  assign total    = IDX_W'(eff_cols) * IDX_W'(eff_rows);
  assign ridx_eff = (ridx_r >= total) ? '0 : ridx_r;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      cell_sz_x_r <= CELL_SZ_RST;
      cell_sz_y_r <= CELL_SZ_RST;
      grid_cols_r <= GRID_DIM_RST;
      grid_rows_r <= GRID_DIM_RST;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_ORIGIN_X:  origin_x_r  <= cfg_data;
        CFG_ORIGIN_Y:  origin_y_r  <= cfg_data;
        CFG_CELL_SZ_X: cell_sz_x_r <= cfg_data[SIZE_W-1:0];
        CFG_CELL_SZ_Y: cell_sz_y_r <= cfg_data[SIZE_W-1:0];
        CFG_GRID_COLS: grid_cols_r <= cfg_data[GRID_W-1:0];
        CFG_GRID_ROWS: grid_rows_r <= cfg_data[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  // control registers: readout position and clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ridx_r     <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cmd.wrap_idx) begin
        ridx_r <= ridx_eff;
      end else if (cmd.adv_idx) begin
        ridx_r <= last_r ? '0 : ridx_r + IDX_W'(1);
      end
    end
  end

  // item capture and offsets from the origin
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      dx_r   <= $signed({in_x[COORD_W-1], in_x}) - $signed({origin_x_r[COORD_W-1], origin_x_r});
      dy_r   <= $signed({in_y[COORD_W-1], in_y}) - $signed({origin_y_r[COORD_W-1], origin_y_r});
      pt_z_r <= in_tdata[3*COORD_W-1:2*COORD_W];
    end
  end

  // divider operand select
  always_comb begin
    unique case (cmd.div_sel)
      DIV_X: begin
        div_dividend = {dx_r[COORD_W-1:0], {(DIV_W-COORD_W){1'b0}}};
        div_divisor  = cell_sz_x_r;
        div_iters    = PT_ITERS;
      end
      DIV_Y: begin
        div_dividend = {dy_r[COORD_W-1:0], {(DIV_W-COORD_W){1'b0}}};
        div_divisor  = cell_sz_y_r;
        div_iters    = PT_ITERS;
      end
      DIV_IDX: begin
        div_dividend = {ridx_eff, {(DIV_W-IDX_W){1'b0}}};
        div_divisor  = SIZE_W'(eff_cols);
        div_iters    = IDX_ITERS;
      end
      DIV_MEAN: begin
        div_dividend = sum_mag;
        div_divisor  = rdata_r.cnt;
        div_iters    = MEAN_ITERS;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
        div_iters    = '0;
      end
    endcase
  end

  // magnitude of the stored height sum
  assign sum_mag = rdata_r.sum[SUM_W-1] ? SUM_W'(-rdata_r.sum) : SUM_W'(rdata_r.sum);
  assign quot_lo = div_q[COORD_W-1:0];

  pgh_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .iters     (div_iters),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // capture of cell position, readout flags and mean
  always_ff @(posedge clk) begin
    if (cmd.cap_x) begin
      col_r    <= div_q[CW-1:0];
      col_ok_r <= quot_lo < COORD_W'(eff_cols);
    end
    if (cmd.cap_y) begin
      row_r    <= div_q[RW-1:0];
      row_ok_r <= quot_lo < COORD_W'(eff_rows);
    end
    if (cmd.cap_idx) begin
      row_r  <= div_q[RW-1:0];
      col_r  <= div_rem[CW-1:0];
      last_r <= ridx_r == (total - IDX_W'(1));
    end
    if (cmd.cap_mean) begin
      mean_r <= rdata_r.sum[SUM_W-1] ? -quot_lo : quot_lo;
    end
  end

  // cell memory: clearing sweep, point update, readout clear
  assign cell_addr = AW'(row_r) * AW'(MAX_COLS) + AW'(col_r);
  assign mem_addr  = cmd.clr_step ? clr_addr_r : cell_addr;
  assign sat       = rdata_r.cnt == '1;

  always_comb begin
    upd_cell.cnt = rdata_r.cnt + CNT_W'(1);
    upd_cell.sum = rdata_r.sum + {{(SUM_W-COORD_W){pt_z_r[COORD_W-1]}}, pt_z_r};
  end

  assign mem_we    = cmd.clr_step | cmd.mem_clr | (cmd.mem_upd & ~sat);
  assign mem_wdata = cmd.mem_upd ? upd_cell : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // result register
  assign row_ext = 16'(row_r);
  assign col_ext = 16'(col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row_r  <= row_ext[OUT_RC_W-1:0];
      out_col_r  <= col_ext[OUT_RC_W-1:0];
      out_cnt_r  <= rdata_r.cnt;
      out_mean_r <= (rdata_r.cnt == '0) ? '0 : mean_r;
      out_surf_r <= rdata_r.cnt != '0;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                       out_mean_r, out_cnt_r, out_col_r, out_row_r};
  assign out_tuser  = out_surf_r;
  assign out_tlast  = out_last_r;

  // status to the controller
  always_comb begin
    sts.div_busy   = div_busy;
    sts.div_done   = div_done;
    sts.clr_last   = clr_addr_r == AW'(CELLS - 1);
    sts.pt_reject  = (cell_sz_x_r == '0) || (cell_sz_y_r == '0) || dx_r[COORD_W] || dy_r[COORD_W];
    sts.cell_ok    = col_ok_r && row_ok_r;
    sts.cell_empty = rdata_r.cnt == '0;
    sts.out_free   = ~out_tvalid_r | out_tready;
  end

  // checks
  `PGH_ASSERT_IMP(a_out_load_free, clk, rst_n, cmd.out_load, sts.out_free)
  `PGH_ASSERT_IMP(a_div_start_idle, clk, rst_n, cmd.div_start, !div_busy)
  `PGH_ASSERT_IMP(a_cap_on_done, clk, rst_n, cmd.cap_x || cmd.cap_y || cmd.cap_idx || cmd.cap_mean, div_done)
  `PGH_ASSERT_IMP(a_upd_after_read, clk, rst_n, cmd.mem_upd, $past(cmd.mem_rd))
  `PGH_ASSERT_NXT(a_out_last_follows, clk, rst_n, cmd.out_load, out_tvalid_r && (out_last_r == $past(last_r)))

endmodule

[sv/pgh_ctrl.sv]
// controller state machine sequencing point and readout requests
module pgh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tuser,
  output logic               in_tready,
  output pgh_pkg::pgh_cmd_t  cmd,
  input  pgh_pkg::pgh_sts_t  sts
);
  import pgh_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PT_CHK,
    ST_PT_DX,
    ST_PT_DY,
    ST_PT_CELL,
    ST_PT_UPD,
    ST_RD_IDX,
    ST_RD_IDXW,
    ST_RD_MEM,
    ST_RD_DATA,
    ST_RD_MEAN,
    ST_RD_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = state_r == ST_IDLE;

  // next state and datapath commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_sel = DIV_X;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = (in_tuser == CMD_READ) ? ST_RD_IDX : ST_PT_CHK;
        end
      end
      // point: drop on bad offset or cell size, else divide x then y
      ST_PT_CHK: begin
        if (sts.pt_reject) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_X;
          state_nxt     = ST_PT_DX;
        end
      end
      ST_PT_DX: begin
        if (sts.div_done) begin
          cmd.cap_x     = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_Y;
          state_nxt     = ST_PT_DY;
        end
      end
      ST_PT_DY: begin
        if (sts.div_done) begin
          cmd.cap_y = 1'b1;
          state_nxt = ST_PT_CELL;
        end
      end
      ST_PT_CELL: begin
        if (sts.cell_ok) begin
          cmd.mem_rd = 1'b1;
          state_nxt  = ST_PT_UPD;
        end else begin
          state_nxt  = ST_IDLE;
        end
      end
      ST_PT_UPD: begin
        cmd.mem_upd = 1'b1;
        state_nxt   = ST_IDLE;
      end
      // readout: split raster index into row and column
      ST_RD_IDX: begin
        cmd.wrap_idx  = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_IDX;
        state_nxt     = ST_RD_IDXW;
      end
      ST_RD_IDXW: begin
        if (sts.div_done) begin
          cmd.cap_idx = 1'b1;
          state_nxt   = ST_RD_MEM;
        end
      end
      ST_RD_MEM: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        if (sts.cell_empty) begin
          state_nxt = ST_RD_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_MEAN;
          state_nxt     = ST_RD_MEAN;
        end
      end
      ST_RD_MEAN: begin
        if (sts.div_done) begin
          cmd.cap_mean = 1'b1;
          state_nxt    = ST_RD_EMIT;
        end
      end
      // hand the cell over and clear it
      ST_RD_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.mem_clr  = 1'b1;
          cmd.adv_idx  = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/point_grid_height_binning.sv]
// top level of the point grid height binning block
//
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | tuser: cmd; tdata: pt_x, pt_y, pt_z
//  out_    | master    | out_tvalid/out_tready| tdata: row, col, count, mean;
//          |           |                      | tuser: is_surface; tlast: last_cell
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_addr: register index; cfg_data
//
// one request at a time, all divisions on one shared bit-serial divider
// point request: two 24-step divisions, none when dropped early
// readout request: a 14-step index division and a 40-step mean division,
// the mean division skipped for an empty cell
// after reset a clearing pass writes every cell before in_tready
// a finished result waits in the output register while the next request is taken
module point_grid_height_binning #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: pt_x [23:0], pt_y [47:24], pt_z [71:48]
  input  logic [pgh_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tuser: cmd
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: cell_row [5:0], cell_col [11:6], hit_count [27:12], mean_height [51:28]
  output logic [pgh_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // tuser: is_surface
  output logic                              out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pgh_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pgh_pkg::COORD_W-1:0]       cfg_data
);
  import pgh_pkg::*;

  pgh_cmd_t cmd;
  pgh_sts_t sts;

  pgh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  pgh_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
